// ===== rtl/cvp_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cvp_pkg
// Shared types and constants for the camera view projection core.
// -----------------------------------------------------------------------------
package cvp_pkg;

   localparam int OUT_W     = 32;
   localparam int Q_BITS    = 32;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAM_POS_X  = 4'd0,
      CSR_CAM_POS_Y  = 4'd1,
      CSR_CAM_POS_Z  = 4'd2,
      CSR_SIN_PITCH  = 4'd3,
      CSR_COS_PITCH  = 4'd4,
      CSR_SIN_YAW    = 4'd5,
      CSR_COS_YAW    = 4'd6,
      CSR_NEAR_PLANE = 4'd7
   } csr_index_type;

   // One divider lane: partial remainder, dividend bits still to shift in,
   // quotient built so far, result sign and overflow.
   typedef struct packed {
      logic [Q_BITS-1:0] rem;
      logic [Q_BITS-1:0] nlo;
      logic [Q_BITS-1:0] quo;
      logic              neg;
      logic              ovf;
   } div_lane_type;

   typedef struct packed {
      div_lane_type      lane_x;
      div_lane_type      lane_y;
      logic [Q_BITS-1:0] dmag;
      logic [OUT_W-1:0]  view_x;
      logic [OUT_W-1:0]  view_y;
      logic [OUT_W-1:0]  view_depth;
      logic              fault;
   } div_stage_type;

endpackage

// ===== rtl/camera_view_projection_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// camera_view_projection_core
// World point to camera space (yaw then pitch) and perspective projection.
// -----------------------------------------------------------------------------
//  channel | ports                              | direction
//  req     | req_valid, req_stall, req_world_*  | in  : one world point, Q16.16
//  rsp     | rsp_valid, rsp_stall, rsp_*        | out : view point, screen point
//  csr     | csr_wr_en, csr_index, csr_wdata    | in  : register writes
//
// One point enters per cycle while the input is not stalled. The pipe has 7
// transform and setup stages, 32 radix-2 divider stages and one output
// register. The divider stages, one quotient bit each, set the depth. Every
// stage advances when it is empty or its successor advances, so bubbles
// collapse and a stalled result only backs up the pipe once it is full. Reset
// clears the valid bits and loads the register reset values.
// -----------------------------------------------------------------------------
module camera_view_projection_core
   import cvp_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 16,
   parameter int TRIG_FRAC_BITS  = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_world_x,
   input  logic [31:0]          req_world_y,
   input  logic [31:0]          req_world_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_view_x,
   output logic [31:0]          rsp_view_y,
   output logic [31:0]          rsp_view_depth,
   output logic [31:0]          rsp_screen_x,
   output logic [31:0]          rsp_screen_y,
   output logic                 rsp_depth_fault,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   // Differences need 34 bits: -wy - cy can reach 2^32.
   localparam int DW   = 34;
   localparam int PW   = DW + 16;
   localparam int SW   = PW + 1;
   localparam int XW   = SW - TRIG_FRAC_BITS;
   localparam int PW2  = XW + 16;
   localparam int SW2  = PW2 + 1;
   localparam int YW   = SW2 - TRIG_FRAC_BITS;
   localparam int NMW  = 49;
   localparam int NW   = 48 + COORD_FRAC_BITS;
   localparam int HW   = NW - Q_BITS;
   localparam int NDIV = Q_BITS;
   localparam int ST_G = 6;
   localparam int NS   = ST_G + NDIV + 2;
   localparam longint HALF = longint'(1) << (TRIG_FRAC_BITS - 1);

   localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   function automatic logic [OUT_W-1:0] sat32(input logic signed [63:0] v);
      logic [OUT_W-1:0] r;
      if ((v[63:OUT_W-1] == '0) || (v[63:OUT_W-1] == '1)) begin
         r = v[OUT_W-1:0];
      end else if (v[63]) begin
         r = SAT_MIN;
      end else begin
         r = SAT_MAX;
      end
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] finish(input div_lane_type l);
      logic [OUT_W-1:0] r;
      if (l.ovf) begin
         r = l.neg ? SAT_MIN : SAT_MAX;
      end else if (!l.neg) begin
         r = l.quo[Q_BITS-1] ? SAT_MAX : l.quo;
      end else if (l.quo > {1'b1, {(Q_BITS-1){1'b0}}}) begin
         r = SAT_MIN;
      end else begin
         r = OUT_W'(-l.quo);
      end
      return r;
   endfunction

   function automatic div_lane_type div_step(input div_lane_type l,
                                             input logic [Q_BITS-1:0] d);
      div_lane_type     o;
      logic [Q_BITS:0]  t;
      logic             take;
      o    = l;
      t    = {l.rem, l.nlo[Q_BITS-1]};
      take = (t >= {1'b0, d});
      o.rem = take ? Q_BITS'(t - {1'b0, d}) : t[Q_BITS-1:0];
      o.nlo = {l.nlo[Q_BITS-2:0], 1'b0};
      o.quo = {l.quo[Q_BITS-2:0], take};
      return o;
   endfunction

   // Advance both lanes of one divider stage by one quotient bit.
   function automatic div_stage_type div_stage_step(input div_stage_type s);
      div_stage_type o;
      o        = s;
      o.lane_x = div_step(s.lane_x, s.dmag);
      o.lane_y = div_step(s.lane_y, s.dmag);
      return o;
   endfunction

   // ---------------------------------------------------------------- registers
   logic signed [31:0] cam_pos_x_ff, cam_pos_y_ff, cam_pos_z_ff;
   logic signed [15:0] sin_pitch_ff, cos_pitch_ff, sin_yaw_ff, cos_yaw_ff;
   logic        [15:0] near_plane_ff;

   // The user must write configuration only while the pipe is empty; the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         cam_pos_x_ff  <= 32'sd65536;
         cam_pos_y_ff  <= 32'sd0;
         cam_pos_z_ff  <= 32'sd65536;
         sin_pitch_ff  <= 16'sd0;
         cos_pitch_ff  <= 16'sd16384;
         sin_yaw_ff    <= 16'sd0;
         cos_yaw_ff    <= 16'sd16384;
         near_plane_ff <= 16'd200;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_CAM_POS_X:  cam_pos_x_ff  <= csr_wdata;
            CSR_CAM_POS_Y:  cam_pos_y_ff  <= csr_wdata;
            CSR_CAM_POS_Z:  cam_pos_z_ff  <= csr_wdata;
            CSR_SIN_PITCH:  sin_pitch_ff  <= csr_wdata[15:0];
            CSR_COS_PITCH:  cos_pitch_ff  <= csr_wdata[15:0];
            CSR_SIN_YAW:    sin_yaw_ff    <= csr_wdata[15:0];
            CSR_COS_YAW:    cos_yaw_ff    <= csr_wdata[15:0];
            CSR_NEAR_PLANE: near_plane_ff <= csr_wdata[15:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // Stage i loads when it is empty or stage i+1 loads this cycle.
   logic [NS-1:0] vld_ff, vld_in;
   logic [NS:0]   adv;

   always_comb begin
      adv[NS] = !rsp_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      for (int i = 0; i < NS; i++) begin
         if (adv[i]) begin
            vld_in[i] = (i == 0) ? req_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !adv[0];

   // ---------------------------------------------------------------- stage A
   // Negate y and z, subtract the camera position.
   logic signed [DW-1:0] a_dx_ff, a_dy_ff, a_dz_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_dx_ff <= DW'($signed(req_world_x)) - DW'(cam_pos_x_ff);
         a_dy_ff <= -DW'($signed(req_world_y)) - DW'(cam_pos_y_ff);
         a_dz_ff <= -DW'($signed(req_world_z)) - DW'(cam_pos_z_ff);
      end
   end

   // ---------------------------------------------------------------- stage B
   // Yaw products.
   logic signed [PW-1:0] b_cdx_ff, b_sdz_ff, b_cdz_ff, b_sdx_ff;
   logic signed [DW-1:0] b_dy_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         b_cdx_ff <= PW'(cos_yaw_ff) * PW'(a_dx_ff);
         b_sdz_ff <= PW'(sin_yaw_ff) * PW'(a_dz_ff);
         b_cdz_ff <= PW'(cos_yaw_ff) * PW'(a_dz_ff);
         b_sdx_ff <= PW'(sin_yaw_ff) * PW'(a_dx_ff);
         b_dy_ff  <= a_dy_ff;
      end
   end

   // ---------------------------------------------------------------- stage C
   // Yaw sums, round half up.
   logic signed [SW-1:0] c_xs, c_zs;
   logic signed [XW-1:0] c_x1_ff, c_z1_ff;
   logic signed [DW-1:0] c_dy_ff;

   assign c_xs = SW'(b_cdx_ff) - SW'(b_sdz_ff) + SW'(HALF);
   assign c_zs = SW'(b_cdz_ff) + SW'(b_sdx_ff) + SW'(HALF);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         c_x1_ff <= XW'(c_xs >>> TRIG_FRAC_BITS);
         c_z1_ff <= XW'(c_zs >>> TRIG_FRAC_BITS);
         c_dy_ff <= b_dy_ff;
      end
   end

   // ---------------------------------------------------------------- stage D
   // Pitch products.
   logic signed [PW2-1:0] d_cdy_ff, d_sz1_ff, d_cz1_ff, d_sdy_ff;
   logic signed [XW-1:0]  d_x1_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         d_cdy_ff <= PW2'(cos_pitch_ff) * PW2'(c_dy_ff);
         d_sz1_ff <= PW2'(sin_pitch_ff) * PW2'(c_z1_ff);
         d_cz1_ff <= PW2'(cos_pitch_ff) * PW2'(c_z1_ff);
         d_sdy_ff <= PW2'(sin_pitch_ff) * PW2'(c_dy_ff);
         d_x1_ff  <= c_x1_ff;
      end
   end

   // ---------------------------------------------------------------- stage E
   // Pitch sums, round, saturate to the view point.
   logic signed [SW2-1:0] e_ys, e_zs;
   logic signed [YW-1:0]  e_y2, e_z2;
   logic [OUT_W-1:0]      e_vx_ff, e_vy_ff, e_vd_ff;

   assign e_ys = SW2'(d_cdy_ff) + SW2'(d_sz1_ff) + SW2'(HALF);
   assign e_zs = SW2'(d_cz1_ff) - SW2'(d_sdy_ff) + SW2'(HALF);
   assign e_y2 = YW'(e_ys >>> TRIG_FRAC_BITS);
   assign e_z2 = YW'(e_zs >>> TRIG_FRAC_BITS);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         e_vx_ff <= sat32(64'(d_x1_ff));
         e_vy_ff <= sat32(64'(e_y2));
         e_vd_ff <= sat32(64'(e_z2));
      end
   end

   // ---------------------------------------------------------------- stage F
   // Scale by the near plane.
   logic signed [NMW-1:0] f_nx_ff, f_ny_ff;
   logic [OUT_W-1:0]      f_vx_ff, f_vy_ff, f_vd_ff;
   logic                  f_fault_ff;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         f_nx_ff    <= NMW'($signed(e_vx_ff)) * NMW'($signed({1'b0, near_plane_ff}));
         f_ny_ff    <= NMW'($signed(e_vy_ff)) * NMW'($signed({1'b0, near_plane_ff}));
         f_vx_ff    <= e_vx_ff;
         f_vy_ff    <= e_vy_ff;
         f_vd_ff    <= e_vd_ff;
         f_fault_ff <= (e_vd_ff == '0);
      end
   end

   // ---------------------------------------------------------------- stage G
   // Magnitudes, overflow test, divider setup. Quotient is
   // |num| * 2^COORD_FRAC_BITS / |depth|; it overflows 32 bits when the
   // dividend's upper part already reaches the divisor.
   logic [Q_BITS-1:0] g_dmag;
   div_stage_type     g_setup;
   div_stage_type     div_ff [0:NDIV];

   function automatic div_lane_type lane_setup(input logic signed [NMW-1:0] num,
                                               input logic depth_neg,
                                               input logic [Q_BITS-1:0] dmag);
      div_lane_type    l;
      logic [47:0]     mag;
      logic [NW-1:0]   nn;
      logic [HW-1:0]   hi;
      mag   = num[NMW-1] ? 48'(-num) : 48'(num);
      nn    = {mag, {COORD_FRAC_BITS{1'b0}}};
      hi    = nn[NW-1:Q_BITS];
      l.ovf = (64'(hi) >= 64'(dmag));
      l.neg = num[NMW-1] ^ depth_neg;
      l.rem = Q_BITS'(hi);
      l.nlo = nn[Q_BITS-1:0];
      l.quo = '0;
      return l;
   endfunction

   assign g_dmag = f_vd_ff[OUT_W-1] ? Q_BITS'(-f_vd_ff) : f_vd_ff;

   always_comb begin
      g_setup.lane_x     = lane_setup(f_nx_ff, f_vd_ff[OUT_W-1], g_dmag);
      g_setup.lane_y     = lane_setup(f_ny_ff, f_vd_ff[OUT_W-1], g_dmag);
      g_setup.dmag       = g_dmag;
      g_setup.view_x     = f_vx_ff;
      g_setup.view_y     = f_vy_ff;
      g_setup.view_depth = f_vd_ff;
      g_setup.fault      = f_fault_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_G]) begin
         div_ff[0] <= g_setup;
      end
   end

   // ---------------------------------------------------------------- divider
   // One restoring step per stage, both lanes share the divisor.
   for (genvar k = 1; k <= NDIV; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv[ST_G + k]) begin
            div_ff[k] <= div_stage_step(div_ff[k-1]);
         end
      end
   end

   // ---------------------------------------------------------------- output
   // Apply sign and saturation; zero depth forces the screen outputs.
   logic [OUT_W-1:0] rsp_view_x_ff, rsp_view_y_ff, rsp_view_depth_ff;
   logic [OUT_W-1:0] rsp_screen_x_ff, rsp_screen_y_ff;
   logic             rsp_depth_fault_ff;
   div_stage_type    last;

   assign last = div_ff[NDIV];

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         rsp_view_x_ff      <= last.view_x;
         rsp_view_y_ff      <= last.view_y;
         rsp_view_depth_ff  <= last.view_depth;
         rsp_depth_fault_ff <= last.fault;
         if (last.fault) begin
            rsp_screen_x_ff <= last.view_x[OUT_W-1] ? SAT_MIN : SAT_MAX;
            rsp_screen_y_ff <= last.view_y[OUT_W-1] ? SAT_MIN : SAT_MAX;
         end else begin
            rsp_screen_x_ff <= finish(last.lane_x);
            rsp_screen_y_ff <= finish(last.lane_y);
         end
      end
   end

   assign rsp_valid       = vld_ff[NS-1];
   assign rsp_view_x      = rsp_view_x_ff;
   assign rsp_view_y      = rsp_view_y_ff;
   assign rsp_view_depth  = rsp_view_depth_ff;
   assign rsp_screen_x    = rsp_screen_x_ff;
   assign rsp_screen_y    = rsp_screen_y_ff;
   assign rsp_depth_fault = rsp_depth_fault_ff;

endmodule

// ===== test/tb_camera_view_projection_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_camera_view_projection_core
// Self-checking regression for the camera view projection core.
// -----------------------------------------------------------------------------
// World points go in on the req channel with random gaps. Each point is run
// through a predictor of the view transform and the perspective divide, using
// the register values that are live at that moment. The expected result is
// queued, and every transfer on the rsp channel is checked field by field
// against the oldest entry in the queue. Registers are changed only while the
// pipe is drained. One phase holds the result side off for a long stretch, so
// the pipe fills and the core has to stall its input.
// -----------------------------------------------------------------------------
module tb_camera_view_projection_core
   import cvp_pkg::*;
();

   localparam int CLK_HALF  = 4;
   localparam int LATENCY   = 40;
   localparam int WDOG_MAX  = 5000;
   localparam int TRIG_FRAC = 14;
   localparam int COORD_FRAC = 16;

   typedef struct {
      logic [31:0] view_x;
      logic [31:0] view_y;
      logic [31:0] view_depth;
      logic [31:0] screen_x;
      logic [31:0] screen_y;
      logic        depth_fault;
   } projection_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_world_x;
   logic [31:0] req_world_y;
   logic [31:0] req_world_z;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_view_x;
   logic [31:0] rsp_view_y;
   logic [31:0] rsp_view_depth;
   logic [31:0] rsp_screen_x;
   logic [31:0] rsp_screen_y;
   logic        rsp_depth_fault;
   logic        csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   // Shadow copy of the register file, as the core should hold it.
   logic signed [31:0] cam_x, cam_y, cam_z;
   logic signed [15:0] sin_pitch, cos_pitch, sin_yaw, cos_yaw;
   logic        [15:0] near_dist;

   projection_type expected_q[$];
   int  error_count;
   int  idle_cycles;
   bit  hold_off;       // long receiver hold-off requested
   int  hold_len;

   camera_view_projection_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_world_x     (req_world_x),
      .req_world_y     (req_world_y),
      .req_world_z     (req_world_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_view_x      (rsp_view_x),
      .rsp_view_y      (rsp_view_y),
      .rsp_view_depth  (rsp_view_depth),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_depth_fault (rsp_depth_fault),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   // Round half up by 2^TRIG_FRAC; arithmetic shift floors, which is what we want.
   function automatic longint trig_round(longint v);
      return (v + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // view * near * 2^16 / depth, truncated toward zero. Split into integer and
   // fraction parts so nothing overflows 64 bits.
   function automatic longint perspective_divide(longint v, longint d, longint n);
      longint num, q, r, lim;
      num = v * n;
      q   = num / d;
      r   = num % d;
      lim = 64'sd1 <<< 33;
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      return clamp32(q * (64'sd1 <<< COORD_FRAC) + (r * (64'sd1 <<< COORD_FRAC)) / d);
   endfunction

   function automatic projection_type project_point(logic [31:0] wx, logic [31:0] wy,
                                                    logic [31:0] wz);
      projection_type p;
      longint dx, dy, dz, x1, z1, y2, z2, vx, vy, vd, sx, sy;
      dx = longint'($signed(wx)) - longint'(cam_x);
      dy = -longint'($signed(wy)) - longint'(cam_y);
      dz = -longint'($signed(wz)) - longint'(cam_z);
      x1 = trig_round(longint'(cos_yaw) * dx - longint'(sin_yaw) * dz);
      z1 = trig_round(longint'(cos_yaw) * dz + longint'(sin_yaw) * dx);
      y2 = trig_round(longint'(cos_pitch) * dy + longint'(sin_pitch) * z1);
      z2 = trig_round(longint'(cos_pitch) * z1 - longint'(sin_pitch) * dy);
      vx = clamp32(x1);
      vy = clamp32(y2);
      vd = clamp32(z2);
      p.depth_fault = (vd == 0);
      if (vd == 0) begin
         sx = (vx >= 0) ? 64'sd2147483647 : -64'sd2147483648;
         sy = (vy >= 0) ? 64'sd2147483647 : -64'sd2147483648;
      end else begin
         sx = perspective_divide(vx, vd, longint'(near_dist));
         sy = perspective_divide(vy, vd, longint'(near_dist));
      end
      p.view_x     = vx[31:0];
      p.view_y     = vy[31:0];
      p.view_depth = vd[31:0];
      p.screen_x   = sx[31:0];
      p.screen_y   = sy[31:0];
      return p;
   endfunction

   // ---------------------------------------------------------------- drivers
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_world_x = '0;
      req_world_y = '0;
      req_world_z = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_CAM_POS_X;
      csr_wdata   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Update the shadow copy along with the write; drop writes past the last index.
   // The caller drops the write enable after its last write.
   task automatic write_register(csr_index_type idx, logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_CAM_POS_X:  cam_x = value;
         CSR_CAM_POS_Y:  cam_y = value;
         CSR_CAM_POS_Z:  cam_z = value;
         CSR_SIN_PITCH:  sin_pitch = value[15:0];
         CSR_COS_PITCH:  cos_pitch = value[15:0];
         CSR_SIN_YAW:    sin_yaw = value[15:0];
         CSR_COS_YAW:    cos_yaw = value[15:0];
         CSR_NEAR_PLANE: near_dist = value[15:0];
         default: ;
      endcase
   endtask

   task automatic load_camera(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [15:0] sp, logic [15:0] cp, logic [15:0] sy,
                              logic [15:0] cy, logic [15:0] np);
      write_register(CSR_CAM_POS_X, px);
      write_register(CSR_CAM_POS_Y, py);
      write_register(CSR_CAM_POS_Z, pz);
      write_register(CSR_SIN_PITCH, {{16{sp[15]}}, sp});
      write_register(CSR_COS_PITCH, {{16{cp[15]}}, cp});
      write_register(CSR_SIN_YAW,   {{16{sy[15]}}, sy});
      write_register(CSR_COS_YAW,   {{16{cy[15]}}, cy});
      write_register(CSR_NEAR_PLANE, {16'h0, np});
      csr_wr_en <= 1'b0;
   endtask

   // Offer one point after a random gap; hold it until the transfer. Valid stays
   // high after the transfer so back-to-back points follow without a gap.
   task automatic send_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_world_x <= wx;
      req_world_y <= wy;
      req_world_z <= wz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(project_point(wx, wy, wz));
   endtask

   // Drop valid, wait for the pipe to empty, then let the tail of the pipe settle.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom();
         3: return $urandom_range(0, 1) ? $urandom_range(0, 200) : -$urandom_range(0, 200);
         default: return 32'($urandom_range(0, 1 << 20)) - 32'h00080000;
      endcase
   endfunction

   function automatic logic [15:0] pick_trig();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'($urandom());
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      // Defaults after reset first.
      send_point(32'h0, 32'h0, 32'hfffe0000);
      send_point(32'h00010000, 32'h0, 32'hffff0000);   // zero depth, fault
      send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_point(32'h80000000, 32'h80000000, 32'h80000000);
      send_point(32'h80000000, 32'h7fffffff, 32'hffff0000);  // fault, negative x
      send_point(32'h00030000, 32'hfffd0000, 32'hfff00000);
      drain_pipe();
      // Extreme registers: trig out of the nominal range, zero near plane.
      load_camera(32'h80000000, 32'h7fffffff, 32'h80000000,
                  16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h0);
      send_point(32'h0, 32'h0, 32'h0);
      send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_point(32'h12345678, 32'hedcba987, 32'h0f0f0f0f);
      drain_pipe();
      load_camera(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  -16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384, 16'hffff);
      send_point(32'h7fffffff, 32'h7fffffff, 32'h80000000);
      send_point(32'h80000000, 32'h80000000, 32'h7fffffff);
      send_point(32'h00000001, 32'hffffffff, 32'h00000001);
      drain_pipe();
      // Identity rotation, camera at origin: depth 0 is reachable directly.
      load_camera(32'h0, 32'h0, 32'h0, 16'h0, 16'sd16384, 16'h0, 16'sd16384, 16'd1);
      send_point(32'hffff0000, 32'h00020000, 32'h0);
      send_point(32'h00050000, 32'h00010000, 32'hfffb0000);
      send_point(32'h00000001, 32'h00000001, 32'hffffffff);
      drain_pipe();
   endtask

   task automatic test_random(int n_sets, int per_set);
      for (int s = 0; s < n_sets; s++) begin
         load_camera(($urandom_range(0, 3) == 0) ? $urandom() : pick_coord(),
                     pick_coord(), pick_coord(), pick_trig(), pick_trig(),
                     pick_trig(), pick_trig(),
                     ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom()));
         for (int i = 0; i < per_set; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_point(32'($signed(cam_x)), -cam_y, -cam_z + $urandom_range(0, 1));
            else
               send_point(pick_coord(), pick_coord(), pick_coord());
         end
         drain_pipe();
      end
   endtask

   // Hold the result side off while the sender keeps offering points.
   task automatic test_backpressure();
      hold_len = 300;
      hold_off = 1'b1;
      for (int i = 0; i < 100; i++)
         send_point($urandom(), $urandom(), $urandom());
      drain_pipe();
   endtask

   // ---------------------------------------------------------------- receiver
   initial begin
      int wait_left;
      rsp_stall = 1'b0;
      wait_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_stall <= (wait_left != 0);
         end else if (rsp_valid && !rsp_stall && $urandom_range(0, 2) == 0) begin
            // Stall after this transfer for a random count.
            wait_left = $urandom_range(0, 13);
            rsp_stall <= (wait_left != 0);
         end
      end
   end

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h, expected %h", field, got, want);
   endtask

   // Check every transfer on the result side.
   always @(posedge clock) begin
      projection_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            error_count++;
            $display("unexpected result transfer");
         end else begin
            want = expected_q.pop_front();
            if (rsp_view_x !== want.view_x)
               report_mismatch("view_x", rsp_view_x, want.view_x);
            if (rsp_view_y !== want.view_y)
               report_mismatch("view_y", rsp_view_y, want.view_y);
            if (rsp_view_depth !== want.view_depth)
               report_mismatch("view_depth", rsp_view_depth, want.view_depth);
            if (rsp_screen_x !== want.screen_x)
               report_mismatch("screen_x", rsp_screen_x, want.screen_x);
            if (rsp_screen_y !== want.screen_y)
               report_mismatch("screen_y", rsp_screen_y, want.screen_y);
            if (rsp_depth_fault !== want.depth_fault)
               report_mismatch("depth_fault", 32'(rsp_depth_fault),
                               32'(want.depth_fault));
         end
      end
   end

   // Watchdog: count cycles in which neither channel transfers.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("camera_view_projection_core regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      error_count = 0;
      idle_cycles = 0;
      hold_off    = 1'b0;
      hold_len    = 0;
      cam_x = 32'sd65536;  cam_y = 0;  cam_z = 32'sd65536;
      sin_pitch = 0;  cos_pitch = 16'sd16384;
      sin_yaw = 0;    cos_yaw = 16'sd16384;
      near_dist = 16'd200;
      @(negedge reset);
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(30, 60);
      if (expected_q.size() != 0) error_count++;
      if (error_count == 0)
         $display("camera_view_projection_core regression: pass");
      else
         $display("camera_view_projection_core regression: fail");
      $finish;
   end

endmodule
